[hdl/prh_pkg.sv]
// Shared types, constants and hash round functions for the packet region
// one-at-a-time hash unit. No dependencies.
`default_nettype none

package prh_pkg;

   localparam int DEFAULT_COUNT_WIDTH = 16;

   // Byte positions within the frame
   localparam int LINK_HEADER_BYTES  = 14;
   localparam int FRAME_TYPE_HI_IDX  = 12;
   localparam int FRAME_TYPE_LO_IDX  = 13;
   localparam int PROTOCOL_IDX       = LINK_HEADER_BYTES + 9;
   localparam int TCP_REGION_LAST    = LINK_HEADER_BYTES + 39;
   localparam int RAW_MIN_LAST_INDEX = LINK_HEADER_BYTES + 20;
   localparam int UDP_HEADER_BYTES   = 8;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [3:0]  IP_VERSION_4   = 4'h4;
   localparam logic [7:0]  PROTO_UDP      = 8'h11;
   localparam logic [7:0]  PROTO_TCP      = 8'h06;
   localparam logic [7:0]  PROTO_ICMP     = 8'h01;

   typedef struct packed {
      logic       take;
      logic       last;
      logic [7:0] data;
   } prh_byte_type;

   // One hash round: add the byte, shift-add, shift-xor
   function automatic logic [31:0] prh_mix(input logic [31:0] h, input logic [7:0] b);
      logic [31:0] h1;
      logic [31:0] h2;
      h1 = h + {24'd0, b};
      h2 = h1 + (h1 << 10);
      return h2 ^ (h2 >> 6);
   endfunction

   // First half of the finalizer
   function automatic logic [31:0] prh_finish_a(input logic [31:0] h);
      logic [31:0] h1;
      h1 = h + (h << 3);
      return h1 ^ (h1 >> 11);
   endfunction

   // Second half of the finalizer, then the two's complement magnitude
   function automatic logic [31:0] prh_finish_b(input logic [31:0] h);
      logic [31:0] h1;
      h1 = h + (h << 15);
      return h1[31] ? (32'd0 - h1) : h1;
   endfunction

endpackage

`default_nettype wire

[hdl/prh_track.sv]
// Per-byte tracker: header captures, byte position and the four region hashes.
// Depends on prh_pkg.
`default_nettype none

module prh_track
   import prh_pkg::*;
#(
   parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire prh_byte_type  byte_in,
   output logic [31:0]        pick_value
);

   localparam logic [COUNT_WIDTH-1:0] IDX_MAX = '1;

   logic [31:0]            whole_acc_ff, whole_acc_in;
   logic [31:0]            tcp_acc_ff,   tcp_acc_in;
   logic [31:0]            icmp_acc_ff,  icmp_acc_in;
   logic [31:0]            udp_acc_ff,   udp_acc_in;
   logic [COUNT_WIDTH-1:0] byte_index_ff, byte_index_in;
   logic [15:0]            frame_type_ff, frame_type_in;
   logic [3:0]             ip_version_ff, ip_version_in;
   logic [3:0]             header_words_ff, header_words_in;
   logic [7:0]             ip_protocol_ff, ip_protocol_in;

   logic [15:0] ft_cur;
   logic [3:0]  ver_cur;
   logic [3:0]  hw_cur;
   logic [7:0]  proto_cur;
   logic [6:0]  ip_end;
   logic [6:0]  udp_start;
   logic [31:0] whole_next, tcp_next, icmp_next, udp_next;
   logic        raw;

   always_comb begin
      ft_cur    = frame_type_ff;
      ver_cur   = ip_version_ff;
      hw_cur    = header_words_ff;
      proto_cur = ip_protocol_ff;
      if (byte_index_ff == COUNT_WIDTH'(FRAME_TYPE_HI_IDX)) begin
         ft_cur = {byte_in.data, frame_type_ff[7:0]};
      end else if (byte_index_ff == COUNT_WIDTH'(FRAME_TYPE_LO_IDX)) begin
         ft_cur = {frame_type_ff[15:8], byte_in.data};
      end else if (byte_index_ff == COUNT_WIDTH'(LINK_HEADER_BYTES)) begin
         ver_cur = byte_in.data[7:4];
         hw_cur  = byte_in.data[3:0];
      end else if (byte_index_ff == COUNT_WIDTH'(PROTOCOL_IDX)) begin
         proto_cur = byte_in.data;
      end

      // Regions start from the header length as captured, including this byte
      ip_end    = 7'(LINK_HEADER_BYTES) + {1'b0, hw_cur, 2'b00};
      udp_start = ip_end + 7'(UDP_HEADER_BYTES);

      whole_next = prh_mix(whole_acc_ff, byte_in.data);
      tcp_next   = tcp_acc_ff;
      icmp_next  = icmp_acc_ff;
      udp_next   = udp_acc_ff;
      if (byte_index_ff >= COUNT_WIDTH'(LINK_HEADER_BYTES) &&
          byte_index_ff <= COUNT_WIDTH'(TCP_REGION_LAST)) begin
         tcp_next = prh_mix(tcp_acc_ff, byte_in.data);
      end
      if (byte_index_ff >= COUNT_WIDTH'(ip_end)) begin
         icmp_next = prh_mix(icmp_acc_ff, byte_in.data);
      end
      if (byte_index_ff >= COUNT_WIDTH'(udp_start)) begin
         udp_next = prh_mix(udp_acc_ff, byte_in.data);
      end

      raw = (byte_index_ff >= COUNT_WIDTH'(RAW_MIN_LAST_INDEX)) &&
            (ft_cur == ETHERTYPE_IPV4) && (ver_cur == IP_VERSION_4);

      if (!raw) begin
         pick_value = whole_next;
      end else begin
         case (proto_cur)
            PROTO_UDP:  pick_value = udp_next;
            PROTO_TCP:  pick_value = tcp_next;
            PROTO_ICMP: pick_value = icmp_next;
            default:    pick_value = 32'd0;
         endcase
      end
   end

   always_comb begin
      whole_acc_in    = whole_acc_ff;
      tcp_acc_in      = tcp_acc_ff;
      icmp_acc_in     = icmp_acc_ff;
      udp_acc_in      = udp_acc_ff;
      byte_index_in   = byte_index_ff;
      frame_type_in   = frame_type_ff;
      ip_version_in   = ip_version_ff;
      header_words_in = header_words_ff;
      ip_protocol_in  = ip_protocol_ff;
      if (byte_in.take) begin
         if (byte_in.last) begin
            // clear everything for the next packet
            whole_acc_in    = '0;
            tcp_acc_in      = '0;
            icmp_acc_in     = '0;
            udp_acc_in      = '0;
            byte_index_in   = '0;
            frame_type_in   = '0;
            ip_version_in   = '0;
            header_words_in = '0;
            ip_protocol_in  = '0;
         end else begin
            whole_acc_in    = whole_next;
            tcp_acc_in      = tcp_next;
            icmp_acc_in     = icmp_next;
            udp_acc_in      = udp_next;
            frame_type_in   = ft_cur;
            ip_version_in   = ver_cur;
            header_words_in = hw_cur;
            ip_protocol_in  = proto_cur;
            // saturate on very long packets
            if (byte_index_ff != IDX_MAX) begin
               byte_index_in = byte_index_ff + COUNT_WIDTH'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         whole_acc_ff    <= '0;
         tcp_acc_ff      <= '0;
         icmp_acc_ff     <= '0;
         udp_acc_ff      <= '0;
         byte_index_ff   <= '0;
         frame_type_ff   <= '0;
         ip_version_ff   <= '0;
         header_words_ff <= '0;
         ip_protocol_ff  <= '0;
      end else begin
         whole_acc_ff    <= whole_acc_in;
         tcp_acc_ff      <= tcp_acc_in;
         icmp_acc_ff     <= icmp_acc_in;
         udp_acc_ff      <= udp_acc_in;
         byte_index_ff   <= byte_index_in;
         frame_type_ff   <= frame_type_in;
         ip_version_ff   <= ip_version_in;
         header_words_ff <= header_words_in;
         ip_protocol_ff  <= ip_protocol_in;
      end
   end

endmodule

`default_nettype wire

[hdl/packet_region_oaat_hash_unit.sv]
// Top level of the packet region one-at-a-time hash unit: input register,
// byte tracker, two finalizer stages and the result register.
// Depends on prh_pkg and prh_track.
//
//   channel  direction  ports                               moves
//   req      in         req_valid req_stall req_data_byte   one byte per request
//                       req_last
//   rsp      out        rsp_valid rsp_stall rsp_hash_value  one hash per packet
//
// One byte is taken every cycle while nothing stalls; the byte register and
// the tracker's add-shift-xor round set that figure.
// After its last byte leaves the input register, a packet's hash passes through
// the select register, the first finalizer half, then the second half into the
// result register.
// Each stage holds only while its successor is full and stalled, so bytes
// that are not last keep flowing while a finished hash waits on rsp_stall.
// Synchronous reset clears the tracker's hashes and captures and all valid flags; stage values are not reset.
`default_nettype none

module packet_region_oaat_hash_unit
   import prh_pkg::*;
#(
   parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_hash_value
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_data_ff;
   logic        in_last_ff;
   logic        sel_valid_ff, sel_valid_in;
   logic [31:0] sel_value_ff;
   logic        fin_valid_ff, fin_valid_in;
   logic [31:0] fin_value_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff;

   logic        rsp_go, fin_ready, sel_ready, in_go, in_ready;
   logic [31:0] pick_value;
   prh_byte_type byte_in;

   always_comb begin
      rsp_go    = !rsp_valid_ff || !rsp_stall;
      fin_ready = !fin_valid_ff || rsp_go;
      sel_ready = !sel_valid_ff || fin_ready;
      // a last byte waits for room in the select stage
      in_go     = in_valid_ff && (!in_last_ff || sel_ready);
      in_ready  = !in_valid_ff || in_go;

      in_valid_in  = in_ready  ? req_valid    : in_valid_ff;
      sel_valid_in = sel_ready ? (in_go && in_last_ff) : sel_valid_ff;
      fin_valid_in = fin_ready ? sel_valid_ff : fin_valid_ff;
      rsp_valid_in = rsp_go    ? fin_valid_ff : rsp_valid_ff;

      byte_in.take = in_go;
      byte_in.last = in_last_ff;
      byte_in.data = in_data_ff;
   end

   assign req_stall      = !in_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_value_ff;

   prh_track #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .byte_in    (byte_in),
      .pick_value (pick_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         sel_valid_ff <= 1'b0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         sel_valid_ff <= sel_valid_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last;
      end
      if (sel_ready) begin
         sel_value_ff <= pick_value;
      end
      if (fin_ready) begin
         fin_value_ff <= prh_finish_a(sel_value_ff);
      end
      if (rsp_go) begin
         rsp_value_ff <= prh_finish_b(fin_value_ff);
      end
   end

   a_sel_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(sel_valid_ff) |-> $past(in_valid_ff && in_last_ff))
      else $error("select stage filled without a last byte");

   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      (fin_valid_ff && !rsp_go) |=> (fin_valid_ff && $stable(fin_value_ff)))
      else $error("finalizer stage overwritten while blocked");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("request stalled with an empty input register");

endmodule

`default_nettype wire
